### sv/rbs_pkg.sv
// Package for the room booking scheduler.
// Holds the room table entry type, field widths, opcodes and reset constants.
// No dependencies.
package rbs_pkg;

    localparam int TIME_W       = 48;
    localparam int BOOK_W       = 32;
    localparam int STAMP_W      = 32;
    localparam int ROOM_COUNT_W = 5;
    localparam int ROOM_OUT_W   = 4;
    localparam int MOST_W       = 5;

    localparam int MAX_ROOMS_DEF = 16;

    localparam logic [ROOM_COUNT_W-1:0] ROOM_COUNT_RST = 5'd16;

    // opcode in tuser
    localparam logic OPC_CLEAR = 1'b0;
    localparam logic OPC_BOOK  = 1'b1;

    // most_booked code when no room has a booking
    localparam logic [MOST_W-1:0] MOST_NONE = 5'h1F;

    typedef struct packed {
        logic [TIME_W-1:0] free_time;
        logic [BOOK_W-1:0] bookings;
    } rbs_entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } rbs_tbl_ctrl_t;

endpackage

### sv/rbs_room_table.sv
// Room table: free time and booking count per room in one synchronous RAM.
// Registered read; per-entry valid bits make unwritten rooms read as zero.
// Depends on rbs_pkg.
module rbs_room_table #(
    parameter int MAX_ROOMS = rbs_pkg::MAX_ROOMS_DEF,
    parameter int IDX_W     = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rbs_pkg::rbs_tbl_ctrl_t ctrl,
    input  logic [IDX_W-1:0]      rd_addr,
    input  logic [IDX_W-1:0]      wr_addr,
    input  rbs_pkg::rbs_entry_t   wr_data,
    output rbs_pkg::rbs_entry_t   rd_data
);
    import rbs_pkg::*;

    rbs_entry_t           mem [MAX_ROOMS];
    logic [MAX_ROOMS-1:0] vld_reg;
    rbs_entry_t           rd_mem_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                vld_reg <= '0;
            end else if (ctrl.wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

### sv/room_booking_scheduler.sv
// Room booking scheduler: gives each booking the lowest room in use that is free
// at its start, or else the room that frees first (lower index on a tie), delaying
// the meeting to that time. A booking is scanned through the room table read port,
// one room per cycle over the rooms in use, then written back when the output is free;
// a clear item only waits for the output. Results sit in an output register, so a
// new item is taken while the previous result waits.
// Depends on rbs_pkg and rbs_room_table.
module room_booking_scheduler #(
    parameter int MAX_ROOMS = rbs_pkg::MAX_ROOMS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rbs_pkg::ROOM_COUNT_W-1:0]  cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // start_time[31:0], end_time[63:32]
    input  logic                              s_tuser,   // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // assigned_room[3:0], begin_time[51:4],
                                                         // most_booked[56:52], zero pad
    output logic                              m_tuser    // out_of_order
);
    import rbs_pkg::*;

    localparam int IDX_W  = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int NUM_W  = $clog2(MAX_ROOMS + 1);
    localparam int RC_W   = (NUM_W > ROOM_COUNT_W) ? NUM_W : ROOM_COUNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_CLR   = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [ROOM_COUNT_W-1:0] room_count_reg;
    logic [STAMP_W-1:0]      start_reg, start_next;
    logic [STAMP_W-1:0]      end_reg, end_next;
    logic [STAMP_W-1:0]      last_start_reg, last_start_next;
    logic                    ooo_reg, ooo_next;
    logic [IDX_W-1:0]        issue_idx_reg, issue_idx_next;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        sel_idx_reg, sel_idx_next;
    logic [TIME_W-1:0]       sel_free_reg, sel_free_next;
    logic [BOOK_W-1:0]       sel_cnt_reg, sel_cnt_next;
    logic [BOOK_W-1:0]       best_cnt_reg, best_cnt_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [63:0]             m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    rbs_tbl_ctrl_t           tbl_ctrl;
    rbs_entry_t              rd_entry;
    rbs_entry_t              wr_entry;

    logic [RC_W-1:0]         rc_ext, rc_use;
    logic [IDX_W-1:0]        last_idx;
    logic                    accept, out_free;
    logic [TIME_W-1:0]       start_ext;
    logic                    hit;
    logic [TIME_W-1:0]       begin_w;
    logic [STAMP_W-1:0]      dur;
    logic [TIME_W:0]         fin_sum;
    logic [TIME_W-1:0]       fin;
    logic                    cnt_sat;
    logic [BOOK_W-1:0]       cnt_new;
    logic [IDX_W+ROOM_OUT_W-1:0] room_wide;
    logic [IDX_W+MOST_W-1:0]     most_wide;
    logic [MOST_W-1:0]       most_code;

    // rooms in use, clamped to 1..MAX_ROOMS
    always_comb begin
        rc_ext = RC_W'(room_count_reg);
        if (rc_ext == '0) begin
            rc_use = RC_W'(1);
        end else if (rc_ext > RC_W'(MAX_ROOMS)) begin
            rc_use = RC_W'(MAX_ROOMS);
        end else begin
            rc_use = rc_ext;
        end
    end
    assign last_idx = IDX_W'(rc_use - RC_W'(1));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign start_ext = TIME_W'(start_reg);
    assign hit       = rd_entry.free_time <= start_ext;

    assign begin_w = found_reg ? start_ext : sel_free_reg;
    assign dur     = (end_reg > start_reg) ? (end_reg - start_reg) : '0;
    assign fin_sum = {1'b0, begin_w} + (TIME_W + 1)'(dur);
    assign fin     = fin_sum[TIME_W] ? {TIME_W{1'b1}} : fin_sum[TIME_W-1:0];
    assign cnt_sat = (sel_cnt_reg == {BOOK_W{1'b1}});
    assign cnt_new = cnt_sat ? sel_cnt_reg : sel_cnt_reg + BOOK_W'(1);

    assign wr_entry.free_time = fin;
    assign wr_entry.bookings  = cnt_new;

    assign tbl_ctrl.rd_en = (state_reg == ST_SCAN);
    assign tbl_ctrl.wr_en = (state_reg == ST_WB) && out_free;
    assign tbl_ctrl.clear = accept && (s_tuser == OPC_CLEAR);

    // running most-booked room: only the room written back can overtake it
    always_comb begin
        best_cnt_next = best_cnt_reg;
        best_idx_next = best_idx_reg;
        if (accept && (s_tuser == OPC_CLEAR)) begin
            best_cnt_next = '0;
            best_idx_next = '0;
        end else if ((state_reg == ST_WB) && out_free && !cnt_sat) begin
            if (cnt_new > best_cnt_reg) begin
                best_cnt_next = cnt_new;
                best_idx_next = sel_idx_reg;
            end else if (cnt_new == best_cnt_reg && sel_idx_reg < best_idx_reg) begin
                best_idx_next = sel_idx_reg;
            end
        end
    end

    assign room_wide = {{ROOM_OUT_W{1'b0}}, sel_idx_reg};
    assign most_wide = {{MOST_W{1'b0}}, best_idx_next};
    assign most_code = (best_cnt_next == '0) ? MOST_NONE : most_wide[MOST_W-1:0];

    always_comb begin
        state_next      = state_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        last_start_next = last_start_reg;
        ooo_next        = ooo_reg;
        issue_idx_next  = issue_idx_reg;
        found_next      = found_reg;
        sel_idx_next    = sel_idx_reg;
        sel_free_next   = sel_free_reg;
        sel_cnt_next    = sel_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        // search over the read stream: first free room, else earliest free
        if (rd_vld_reg && !found_reg) begin
            if (hit) begin
                found_next    = 1'b1;
                sel_idx_next  = rd_idx_reg;
                sel_free_next = rd_entry.free_time;
                sel_cnt_next  = rd_entry.bookings;
            end else if (rd_idx_reg == '0 || rd_entry.free_time < sel_free_reg) begin
                sel_idx_next  = rd_idx_reg;
                sel_free_next = rd_entry.free_time;
                sel_cnt_next  = rd_entry.bookings;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OPC_CLEAR) begin
                        last_start_next = '0;
                        state_next      = ST_CLR;
                    end else begin
                        start_next      = s_tdata[31:0];
                        end_next        = s_tdata[63:32];
                        ooo_next        = s_tdata[31:0] < last_start_reg;
                        last_start_next = s_tdata[31:0];
                        issue_idx_next  = '0;
                        found_next      = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_idx_reg == last_idx) begin
                    state_next = ST_DRAIN;
                end else begin
                    issue_idx_next = issue_idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, most_code, begin_w,
                                     room_wide[ROOM_OUT_W-1:0]};
                    m_tuser_next  = ooo_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_CLR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, MOST_NONE, {TIME_W{1'b0}}, {ROOM_OUT_W{1'b0}}};
                    m_tuser_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            room_count_reg <= ROOM_COUNT_RST;
            last_start_reg <= '0;
            best_cnt_reg   <= '0;
            best_idx_reg   <= '0;
            found_reg      <= 1'b0;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_we) begin
                room_count_reg <= cfg_wdata;
            end
            last_start_reg <= last_start_next;
            best_cnt_reg   <= best_cnt_next;
            best_idx_reg   <= best_idx_next;
            found_reg      <= found_next;
            rd_vld_reg     <= (state_reg == ST_SCAN);
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg     <= start_next;
        end_reg       <= end_next;
        ooo_reg       <= ooo_next;
        issue_idx_reg <= issue_idx_next;
        rd_idx_reg    <= issue_idx_reg;
        sel_idx_reg   <= sel_idx_next;
        sel_free_reg  <= sel_free_next;
        sel_cnt_reg   <= sel_cnt_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    rbs_room_table #(
        .MAX_ROOMS (MAX_ROOMS),
        .IDX_W     (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tbl_ctrl),
        .rd_addr (issue_idx_reg),
        .wr_addr (sel_idx_reg),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a fresh result only follows a write-back or clear step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_WB || $past(state_reg) == ST_CLR))
        else $error("result raised outside write-back or clear");

    // the chosen room is always one of the rooms in use
    a_room_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) |-> (sel_idx_reg <= last_idx))
        else $error("selected room beyond rooms in use");

    // a meeting never begins before its requested start
    a_no_early_begin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) |-> (begin_w >= start_ext))
        else $error("begin time earlier than start time");

endmodule

### tb/sv/booking_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the room booking scheduler: follows both stream channels and the
// configuration port, predicts every allocation and compares it with the result stream.
// Depends on rbs_pkg.
module booking_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [rbs_pkg::ROOM_COUNT_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [63:0]                      s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [63:0]                      m_tdata,
    input  logic                             m_tuser,
    output int                               fail_count,
    output int                               outstanding
);
    import rbs_pkg::*;

    typedef struct packed {
        logic [ROOM_OUT_W-1:0] room;
        logic [TIME_W-1:0]     begin_at;
        logic [MOST_W-1:0]     most;
        logic                  late;
    } allocation_t;

    localparam logic [TIME_W-1:0] TIME_SAT  = '1;
    localparam logic [BOOK_W-1:0] COUNT_SAT = '1;

    logic [TIME_W-1:0]       free_at [MAX_ROOMS_DEF];
    logic [BOOK_W-1:0]       hits    [MAX_ROOMS_DEF];
    logic [STAMP_W-1:0]      prev_start;
    logic [ROOM_COUNT_W-1:0] rooms_reg;
    allocation_t             allocations_due [$];
    int                      errors;

    initial begin
        errors = 0;
    end

    task automatic wipe_rooms();
        for (int i = 0; i < MAX_ROOMS_DEF; i++) begin
            free_at[i] = '0;
            hits[i]    = '0;
        end
        prev_start = '0;
    endtask

    task automatic allocate_room(input logic opc, input logic [31:0] start_t,
                                 input logic [31:0] end_t, output allocation_t res);
        int                  n;
        int                  pick;
        logic                hit;
        logic [TIME_W-1:0]   span;
        logic [TIME_W:0]     sum;
        logic [BOOK_W-1:0]   top_hits;
        res = '0;
        if (opc == OPC_CLEAR) begin
            wipe_rooms();
            res.most = MOST_NONE;
        end else begin
            res.late   = (start_t < prev_start);
            prev_start = start_t;
            span = (end_t > start_t) ? TIME_W'(end_t - start_t) : '0;
            n = int'(rooms_reg);
            if (n == 0)
                n = 1;
            else if (n > MAX_ROOMS_DEF)
                n = MAX_ROOMS_DEF;

            pick = 0;
            hit  = 1'b0;
            for (int i = 0; i < n && !hit; i++) begin
                if (free_at[i] <= TIME_W'(start_t)) begin
                    pick = i;
                    hit  = 1'b1;
                end
            end
            if (hit) begin
                res.begin_at = TIME_W'(start_t);
            end else begin
                // nothing free: earliest to free wins, strict compare keeps the lower index
                for (int i = 1; i < n; i++) begin
                    if (free_at[i] < free_at[pick]) pick = i;
                end
                res.begin_at = free_at[pick];
            end

            sum = {1'b0, res.begin_at} + {1'b0, span};
            free_at[pick] = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
            if (hits[pick] != COUNT_SAT) hits[pick] = hits[pick] + BOOK_W'(1);
            res.room = ROOM_OUT_W'(pick);

            // scan covers every room, including ones above the current count
            res.most = MOST_NONE;
            top_hits = '0;
            for (int i = 0; i < MAX_ROOMS_DEF; i++) begin
                if (hits[i] > top_hits) begin
                    top_hits = hits[i];
                    res.most = MOST_W'(i);
                end
            end
        end
    endtask

    task automatic flag_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
        errors++;
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        allocation_t res;
        allocation_t want;
        if (!aresetn) begin
            wipe_rooms();
            rooms_reg = ROOM_COUNT_RST;
            allocations_due.delete();
        end else begin
            if (cfg_we) rooms_reg = cfg_wdata;

            // result first: it belongs to an earlier transaction than any accepted now
            if (m_tvalid && m_tready) begin
                if (allocations_due.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: expected none, got tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = allocations_due.pop_front();
                    if (m_tdata[3:0] !== want.room)
                        flag_field("assigned_room", 64'(want.room), 64'(m_tdata[3:0]));
                    if (m_tdata[51:4] !== want.begin_at)
                        flag_field("begin_time", 64'(want.begin_at), 64'(m_tdata[51:4]));
                    if (m_tdata[56:52] !== want.most)
                        flag_field("most_booked", 64'(want.most), 64'(m_tdata[56:52]));
                    if (m_tdata[63:57] !== 7'd0)
                        flag_field("tdata padding", 64'd0, 64'(m_tdata[63:57]));
                    if (m_tuser !== want.late)
                        flag_field("out_of_order", 64'(want.late), 64'(m_tuser));
                end
            end

            if (s_tvalid && s_tready) begin
                allocate_room(s_tuser, s_tdata[31:0], s_tdata[63:32], res);
                allocations_due.push_back(res);
            end
        end
        fail_count  <= errors;
        outstanding <= allocations_due.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the room booking scheduler testbench: clock, reset, stimulus and verdict.
// Depends on rbs_pkg, room_booking_scheduler and booking_checker.
module tb;
    import rbs_pkg::*;

    localparam int IDLE_LIMIT = 2000;   // cycles with no transaction on either channel
    localparam int SETTLE     = 25;     // covers a full 16-room scan

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [ROOM_COUNT_W-1:0] cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [63:0]             s_tdata   = '0;
    logic                    s_tuser   = OPC_BOOK;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [63:0]             m_tdata;
    logic                    m_tuser;

    int          fail_count;
    int          outstanding;
    bit          calm = 1'b0;
    logic [31:0] clock_now = '0;

    always #4 aclk = ~aclk;

    room_booking_scheduler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    booking_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic offer(input logic opc, input logic [31:0] start_t,
                         input logic [31:0] end_t);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tuser  = opc;
        s_tdata  = {end_t, start_t};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // room count only changes with the block drained and idle
    task automatic set_rooms(input logic [ROOM_COUNT_W-1:0] rooms);
        s_tvalid = 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE) @(negedge aclk);
        cfg_wdata = rooms;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // mostly ascending bookings with random spacing; some clears, stragglers and junk
    task automatic run_bookings(input int count, input int gap_max, input int len_max);
        int          pick;
        logic [31:0] start_t;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                clock_now = $urandom_range(0, 1000);
                offer(OPC_CLEAR, $urandom, $urandom);
            end else if (pick < 10) begin
                offer(OPC_BOOK, $urandom, $urandom);
            end else if (pick < 15) begin
                start_t = clock_now - $urandom_range(0, gap_max * 4);
                offer(OPC_BOOK, start_t, start_t - $urandom_range(0, 3));
            end else begin
                clock_now = clock_now + $urandom_range(0, gap_max);
                offer(OPC_BOOK, clock_now, clock_now + $urandom_range(1, len_max));
            end
        end
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    initial begin : sink_pacing
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [ROOM_COUNT_W-1:0] plan [8];
        int                      n;
        plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd0};
        plan[7] = ROOM_COUNT_W'($urandom_range(0, 31));

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed: free rooms, zero and negative lengths, stragglers, time extremes
        set_rooms(5'd16);
        offer(OPC_CLEAR, '1, '1);
        offer(OPC_BOOK, 32'd10, 32'd20);
        offer(OPC_BOOK, 32'd10, 32'd30);
        offer(OPC_BOOK, 32'd15, 32'd15);
        offer(OPC_BOOK, 32'd15, 32'd3);
        offer(OPC_BOOK, 32'd5, 32'd8);
        offer(OPC_BOOK, '1, '1);
        offer(OPC_BOOK, 32'd0, '1);

        // all rooms busy: delays and the tie towards the lower room
        set_rooms(5'd2);
        offer(OPC_CLEAR, 32'd0, 32'd0);
        offer(OPC_BOOK, 32'd0, 32'd100);
        offer(OPC_BOOK, 32'd0, 32'd100);
        offer(OPC_BOOK, 32'd0, 32'd1);
        offer(OPC_BOOK, 32'd0, 32'd50);
        offer(OPC_BOOK, 32'd200, 32'd300);

        // zero rooms behaves as one
        set_rooms(5'd0);
        offer(OPC_BOOK, 32'd300, 32'd400);
        offer(OPC_BOOK, 32'd300, 32'd310);

        // free times past 32 bits: full-length bookings stacked in one room
        calm = 1'b1;
        set_rooms(5'd1);
        offer(OPC_CLEAR, 32'd0, 32'd0);
        for (int k = 0; k < 4; k++) offer(OPC_BOOK, 32'd0, '1);
        calm = 1'b0;

        for (int p = 0; p < 8; p++) begin
            if (p == 7) calm = 1'b1;
            set_rooms(plan[p]);
            n = int'(plan[p]);
            if (n == 0)
                n = 1;
            else if (n > MAX_ROOMS_DEF)
                n = MAX_ROOMS_DEF;
            run_bookings(60, 10, 20 * n + 20);
        end

        s_tvalid = 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE) @(negedge aclk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
